// File: hw/rtl/gbts_pkg.sv
// ----------------------------------------------------------------------------
// gbts_pkg
// Shared types and constants of the gap buffer text store.
// ----------------------------------------------------------------------------
`default_nettype none

package gbts_pkg;

  localparam int unsigned ActionW   = 4;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned PosW      = 12;
  localparam int unsigned CountW    = 13;

  localparam logic [ByteW-1:0] NewlineByte = 8'h0A;

  typedef enum logic [ActionW-1:0] {
    ACT_INSERT    = 4'd0,
    ACT_BACKSPACE = 4'd1,
    ACT_LEFT      = 4'd2,
    ACT_RIGHT     = 4'd3,
    ACT_NEXT_LINE = 4'd4,
    ACT_PREV_LINE = 4'd5,
    ACT_TO_START  = 4'd6,
    ACT_CLEAR     = 4'd7,
    ACT_READ      = 4'd8
  } act_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SHL_RD,
    ST_SHL_WR,
    ST_SHR_RD,
    ST_SHR_WR,
    ST_NL_RD,
    ST_NL_CHK,
    ST_PL_RD,
    ST_PL_CHK,
    ST_FLAG,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// File: hw/rtl/gap_buffer_text_store.sv
// Steps: insert, backspace, clear, read, unused codes, and backspace, left, right or previous
// line refused at a boundary step EXEC, FLAG, DONE; a left or right move also moves one byte.
// Line moves scan for a newline, then line moves and to start move bytes across the gap, with
// one extra PL_RD step if the previous line starts at 0; each moved byte is read, then written.
// Throughput: one item at a time; the next beat is taken the cycle after a result is registered.
// Reset: cursor 0, empty buffer; the text store itself is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
// gap_buffer_text_store
// Byte text store with a cursor gap held in one synchronous memory, driven by
// a sequencer that edits, moves bytes across the gap and scans for newlines.
// ----------------------------------------------------------------------------
`default_nettype none

module gap_buffer_text_store #(
  parameter int unsigned CAPACITY = 4096
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [gbts_pkg::ActionW-1:0]    action_i,
  input  wire logic [gbts_pkg::ByteW-1:0]      data_byte_i,
  input  wire logic [gbts_pkg::PosW-1:0]       read_position_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic                                 ok_o,
  output logic [gbts_pkg::ByteW-1:0]           char_out_o,
  output logic [gbts_pkg::CountW-1:0]          cursor_o,
  output logic [gbts_pkg::CountW-1:0]          text_length_o,
  output logic                                 full_res_o,
  output logic                                 at_line_start_o,
  output logic                                 at_line_edge_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned PW = $clog2(CAPACITY + 1);
  localparam int unsigned LW = (PW > gbts_pkg::PosW) ? PW : gbts_pkg::PosW;
  localparam logic [PW-1:0] CapW = PW'(CAPACITY);

  gbts_pkg::state_e state_q, state_d;
  gbts_pkg::act_e   act_q;
  logic [gbts_pkg::ByteW-1:0] data_q;
  logic [gbts_pkg::PosW-1:0]  pos_q;

  logic [PW-1:0] gl_q, gl_d, gr_q, gr_d;
  logic [PW-1:0] scan_q, scan_d, tgt_q, tgt_d;
  logic          ok_q, ok_d, phase_q, phase_d, rdchar_q, rdchar_d;
  logic [gbts_pkg::ByteW-1:0] char_q, char_d;

  logic [gbts_pkg::ByteW-1:0] mem [CAPACITY];
  logic [gbts_pkg::ByteW-1:0] rda_q, rdb_q, mem_wd;
  logic                       mem_we, rea, reb;
  logic [AW-1:0]              mem_wa, raa, rab;

  logic                       out_valid_q;
  logic                       ok_out_q, full_q, lstart_q, ledge_q;
  logic [gbts_pkg::ByteW-1:0] char_out_q;
  logic [gbts_pkg::CountW-1:0] cursor_q, length_q;

  logic [PW-1:0] gl_m1, gr_m1, scan_m1, len;
  logic [LW-1:0] pos_w, len_w, radr_w;
  logic          out_free, accept;

  assign gl_m1   = gl_q - PW'(1);
  assign gr_m1   = gr_q - PW'(1);
  assign scan_m1 = scan_q - PW'(1);
  assign len     = gl_q + (CapW - gr_q);
  assign pos_w   = LW'(pos_q);
  assign len_w   = LW'(len);
  assign radr_w  = (pos_w < LW'(gl_q)) ? pos_w : pos_w + LW'(gr_q - gl_q);

  assign in_stall_o = (state_q != gbts_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d  = state_q;
    gl_d     = gl_q;
    gr_d     = gr_q;
    scan_d   = scan_q;
    tgt_d    = tgt_q;
    ok_d     = ok_q;
    phase_d  = phase_q;
    rdchar_d = rdchar_q;
    char_d   = char_q;
    mem_we   = 1'b0;
    mem_wa   = gl_q[AW-1:0];
    mem_wd   = data_q;
    rea      = 1'b0;
    raa      = '0;
    reb      = 1'b0;
    rab      = '0;
    case (state_q)
      gbts_pkg::ST_IDLE: begin
        if (accept) begin
          ok_d     = 1'b0;
          rdchar_d = 1'b0;
          phase_d  = 1'b0;
          state_d  = gbts_pkg::ST_EXEC;
        end
      end
      gbts_pkg::ST_EXEC: begin
        state_d = gbts_pkg::ST_FLAG;
        case (act_q)
          gbts_pkg::ACT_INSERT: begin
            if (gl_q < gr_q) begin
              mem_we = 1'b1;
              gl_d   = gl_q + PW'(1);
              ok_d   = 1'b1;
            end
          end
          gbts_pkg::ACT_BACKSPACE: begin
            if (gl_q != '0) begin
              gl_d = gl_m1;
              ok_d = 1'b1;
            end
          end
          gbts_pkg::ACT_LEFT: begin
            if (gl_q != '0) begin
              tgt_d   = gl_m1;
              ok_d    = 1'b1;
              state_d = gbts_pkg::ST_SHL_RD;
            end
          end
          gbts_pkg::ACT_RIGHT: begin
            if (gr_q < CapW) begin
              tgt_d   = gr_q + PW'(1);
              ok_d    = 1'b1;
              state_d = gbts_pkg::ST_SHR_RD;
            end
          end
          gbts_pkg::ACT_NEXT_LINE: begin
            scan_d  = gr_q;
            state_d = gbts_pkg::ST_NL_RD;
          end
          gbts_pkg::ACT_PREV_LINE: begin
            if (gl_q != '0) begin
              scan_d  = gl_q;
              state_d = gbts_pkg::ST_PL_RD;
            end
          end
          gbts_pkg::ACT_TO_START: begin
            tgt_d   = '0;
            ok_d    = 1'b1;
            state_d = gbts_pkg::ST_SHL_RD;
          end
          gbts_pkg::ACT_CLEAR: begin
            gl_d = '0;
            gr_d = CapW;
            ok_d = 1'b1;
          end
          gbts_pkg::ACT_READ: begin
            if (pos_w < len_w) begin
              rea      = 1'b1;
              raa      = radr_w[AW-1:0];
              ok_d     = 1'b1;
              rdchar_d = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      gbts_pkg::ST_SHL_RD: begin
        if (gl_q == tgt_q) begin
          state_d = gbts_pkg::ST_FLAG;
        end else begin
          rea     = 1'b1;
          raa     = gl_m1[AW-1:0];
          state_d = gbts_pkg::ST_SHL_WR;
        end
      end
      gbts_pkg::ST_SHL_WR: begin
        mem_we  = 1'b1;
        mem_wa  = gr_m1[AW-1:0];
        mem_wd  = rda_q;
        gl_d    = gl_m1;
        gr_d    = gr_m1;
        state_d = gbts_pkg::ST_SHL_RD;
      end
      gbts_pkg::ST_SHR_RD: begin
        if (gr_q == tgt_q) begin
          state_d = gbts_pkg::ST_FLAG;
        end else begin
          rea     = 1'b1;
          raa     = gr_q[AW-1:0];
          state_d = gbts_pkg::ST_SHR_WR;
        end
      end
      gbts_pkg::ST_SHR_WR: begin
        mem_we  = 1'b1;
        mem_wa  = gl_q[AW-1:0];
        mem_wd  = rda_q;
        gl_d    = gl_q + PW'(1);
        gr_d    = gr_q + PW'(1);
        state_d = gbts_pkg::ST_SHR_RD;
      end
      gbts_pkg::ST_NL_RD: begin
        if (scan_q >= CapW) begin
          state_d = gbts_pkg::ST_FLAG;
        end else begin
          rea     = 1'b1;
          raa     = scan_q[AW-1:0];
          state_d = gbts_pkg::ST_NL_CHK;
        end
      end
      gbts_pkg::ST_NL_CHK: begin
        if (rda_q == gbts_pkg::NewlineByte) begin
          tgt_d   = scan_q + PW'(1);
          ok_d    = 1'b1;
          state_d = gbts_pkg::ST_SHR_RD;
        end else begin
          scan_d  = scan_q + PW'(1);
          state_d = gbts_pkg::ST_NL_RD;
        end
      end
      gbts_pkg::ST_PL_RD: begin
        if (scan_q == '0) begin
          if (phase_q) begin
            tgt_d   = '0;
            ok_d    = 1'b1;
            state_d = gbts_pkg::ST_SHL_RD;
          end else begin
            state_d = gbts_pkg::ST_FLAG;
          end
        end else begin
          rea     = 1'b1;
          raa     = scan_m1[AW-1:0];
          scan_d  = scan_m1;
          state_d = gbts_pkg::ST_PL_CHK;
        end
      end
      gbts_pkg::ST_PL_CHK: begin
        state_d = gbts_pkg::ST_PL_RD;
        if (rda_q == gbts_pkg::NewlineByte) begin
          if (phase_q) begin
            tgt_d   = scan_q + PW'(1);
            ok_d    = 1'b1;
            state_d = gbts_pkg::ST_SHL_RD;
          end else begin
            phase_d = 1'b1;
          end
        end
      end
      gbts_pkg::ST_FLAG: begin
        char_d  = rdchar_q ? rda_q : '0;
        rea     = 1'b1;
        raa     = (gl_q != '0) ? gl_m1[AW-1:0] : '0;
        reb     = 1'b1;
        rab     = (gr_q < CapW) ? gr_q[AW-1:0] : '0;
        state_d = gbts_pkg::ST_DONE;
      end
      gbts_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = gbts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = gbts_pkg::ST_IDLE;
      end
    endcase
  end

  // text store, read-before-write
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rea) begin
      rda_q <= mem[raa];
    end
    if (reb) begin
      rdb_q <= mem[rab];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= gbts_pkg::ST_IDLE;
      gl_q     <= '0;
      gr_q     <= CapW;
      scan_q   <= '0;
      tgt_q    <= '0;
      ok_q     <= 1'b0;
      phase_q  <= 1'b0;
      rdchar_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      gl_q     <= gl_d;
      gr_q     <= gr_d;
      scan_q   <= scan_d;
      tgt_q    <= tgt_d;
      ok_q     <= ok_d;
      phase_q  <= phase_d;
      rdchar_q <= rdchar_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    if (accept) begin
      act_q  <= gbts_pkg::act_e'(action_i);
      data_q <= data_byte_i;
      pos_q  <= read_position_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == gbts_pkg::ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == gbts_pkg::ST_DONE && out_free) begin
      ok_out_q   <= ok_q;
      char_out_q <= char_q;
      cursor_q   <= gbts_pkg::CountW'(gl_q);
      length_q   <= gbts_pkg::CountW'(len);
      full_q     <= (gl_q == gr_q);
      lstart_q   <= (gl_q == '0) || (rda_q == gbts_pkg::NewlineByte);
      ledge_q    <= (gr_q >= CapW) || (rdb_q == gbts_pkg::NewlineByte);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign ok_o            = ok_out_q;
  assign char_out_o      = char_out_q;
  assign cursor_o        = cursor_q;
  assign text_length_o   = length_q;
  assign full_res_o      = full_q;
  assign at_line_start_o = lstart_q;
  assign at_line_edge_o  = ledge_q;

`ifndef NO_ASSERTIONS
  a_gap_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gl_q <= gr_q) && (gr_q <= CapW))
    else $error("gap bounds broken");

  a_shl_keeps_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gbts_pkg::ST_SHL_WR) |=> (PW'(gr_q - gl_q) == $past(PW'(gr_q - gl_q))))
    else $error("left move changed gap size");

  a_shr_keeps_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gbts_pkg::ST_SHR_WR) |=> (PW'(gr_q - gl_q) == $past(PW'(gr_q - gl_q))))
    else $error("right move changed gap size");

  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gbts_pkg::ST_DONE && out_free) |=>
      (out_valid_q && state_q == gbts_pkg::ST_IDLE))
    else $error("result not registered");
`endif

endmodule

`default_nettype wire
